### src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int OCC_W = 4;
    localparam int STATUS_W = 2;

    // Operation codes carried on the input tuser bit.
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // Operation broadcast to every cell of the row.
    typedef struct packed {
        logic                    enq;
        logic                    deq;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } cell_op_t;

endpackage

### src/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell row, fill count and result register.
//
//  Channel   Direction  tdata                                   tuser
//  s_axis    in         [31:0] item_key, [63:32] item_value     [0] kind
//  m_axis    out        [31:0] removed_key, [63:32] removed_value,
//                       [67:64] occupancy, [71:68] zero         [1:0] status
//
// The row of cells compares all stored keys with the new key in parallel and
// shifts together, so one transfer is taken each cycle unless a result stalls.
// The result appears on m_axis the cycle after the input transfer.
// Reset clears the fill count and the result valid; stored pairs need no reset.
// A stalled result holds, and a new input is taken in the same cycle the old
// result leaves.
`timescale 1ns / 1ps

module sorted_priority_queue #(
    parameter int DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] item_key, [63:32] item_value
    input  logic [0:0]  s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [31:0] removed_key, [63:32] removed_value,
                                        // [67:64] occupancy, [71:68] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [CW-1:0]            count_reg, count_next;
    logic                     out_valid_reg;
    status_t                  status_reg, status_next;
    logic signed [KEY_W-1:0]  rkey_reg, rkey_next;
    logic signed [VAL_W-1:0]  rval_reg, rval_next;
    logic [OCC_W-1:0]         occ_reg;

    logic                     in_xfer;
    logic                     in_kind;
    logic                     enq_ok, deq_ok;
    cell_op_t                 op;

    logic                     cell_greater [DEPTH];
    logic signed [KEY_W-1:0]  cell_key     [DEPTH];
    logic signed [VAL_W-1:0]  cell_value   [DEPTH];

    // Input handshake and operation decode.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_kind       = s_axis_tuser[0];
    assign enq_ok        = in_xfer && (in_kind == KIND_ENQ) && (count_reg != FULL);
    assign deq_ok        = in_xfer && (in_kind == KIND_DEQ) && (count_reg != '0);

    assign op.enq   = enq_ok;
    assign op.deq   = deq_ok;
    assign op.key   = s_axis_tdata[31:0];
    assign op.value = s_axis_tdata[63:32];

    // Row of cells, cell 0 holds the largest key.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                    up_greater;
        logic signed [KEY_W-1:0] up_key, lo_key;
        logic signed [VAL_W-1:0] up_value, lo_value;

        if (i == 0)
        begin : g_top
            assign up_greater = 1'b1;
            assign up_key     = '0;
            assign up_value   = '0;
        end
        else
        begin : g_mid
            assign up_greater = cell_greater[i-1];
            assign up_key     = cell_key[i-1];
            assign up_value   = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bottom
            assign lo_key   = '0;
            assign lo_value = '0;
        end
        else
        begin : g_inner
            assign lo_key   = cell_key[i+1];
            assign lo_value = cell_value[i+1];
        end

        spq_cell u_cell (
            .clk          (clk),
            .op           (op),
            .occupied     (CW'(i) < count_reg),
            .upper_greater(up_greater),
            .upper_key    (up_key),
            .upper_value  (up_value),
            .lower_key    (lo_key),
            .lower_value  (lo_value),
            .greater      (cell_greater[i]),
            .key          (cell_key[i]),
            .value        (cell_value[i])
        );
    end

    // Next fill count and result.
    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        rkey_next   = '0;
        rval_next   = '0;
        if (in_kind == KIND_ENQ)
        begin
            if (enq_ok)
                count_next = count_reg + CW'(1);
            else
                status_next = ST_OVERFLOW;
        end
        else
        begin
            if (deq_ok)
            begin
                count_next = count_reg - CW'(1);
                rkey_next  = cell_key[0];
                rval_next  = cell_value[0];
            end
            else
                status_next = ST_UNDERFLOW;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                count_reg <= count_next;
            if (in_xfer)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            status_reg <= status_next;
            rkey_reg   <= rkey_next;
            rval_reg   <= rval_next;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {4'd0, occ_reg, rval_reg, rkey_reg};

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("fill count above capacity");

    // A successful insert grows the count by one.
    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        enq_ok |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the fill count");

    // A successful removal shrinks the count by one.
    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        deq_ok |=> count_reg == $past(count_reg) - CW'(1))
        else $error("removal did not shrink the fill count");

    // Error results carry no removed pair.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> (rkey_reg == '0 && rval_reg == '0))
        else $error("error result carries a removed pair");

endmodule

### src/spq_cell.sv
// One storage cell of the sorted row: holds a key and value pair.
`timescale 1ns / 1ps

module spq_cell (
    input  logic                            clk,
    input  spq_pkg::cell_op_t               op,
    input  logic                            occupied,
    input  logic                            upper_greater,
    input  logic signed [spq_pkg::KEY_W-1:0] upper_key,
    input  logic signed [spq_pkg::VAL_W-1:0] upper_value,
    input  logic signed [spq_pkg::KEY_W-1:0] lower_key,
    input  logic signed [spq_pkg::VAL_W-1:0] lower_value,
    output logic                            greater,
    output logic signed [spq_pkg::KEY_W-1:0] key,
    output logic signed [spq_pkg::VAL_W-1:0] value
);
    import spq_pkg::*;

    logic signed [KEY_W-1:0] key_reg;
    logic signed [VAL_W-1:0] value_reg;

    // A stored entry stays in place on insert only if its key beats the new one.
    assign greater = occupied && (key_reg > op.key);
    assign key     = key_reg;
    assign value   = value_reg;

    // Insert: take the new pair at the boundary, otherwise shift down from above.
    // Remove: shift up from the cell below.
    always_ff @(posedge clk)
    begin
        if (op.enq && !greater)
        begin
            if (upper_greater)
            begin
                key_reg   <= op.key;
                value_reg <= op.value;
            end
            else
            begin
                key_reg   <= upper_key;
                value_reg <= upper_value;
            end
        end
        else if (op.deq)
        begin
            key_reg   <= lower_key;
            value_reg <= lower_value;
        end
    end

endmodule

### tb/spq_result_check.sv
// Result checker for the sorted priority queue: predicts every result and compares it.
`timescale 1ns / 1ps

module spq_result_check #(
    parameter int DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] item_key, [63:32] item_value
    input  logic [0:0]  s_axis_tuser,   // [0] kind
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,   // [31:0] removed_key, [63:32] removed_value,
                                        // [67:64] occupancy, [71:68] zero
    input  logic [1:0]  m_axis_tuser,   // [1:0] status
    output int          fail_count,
    output int          pending,
    output int          ok_seen,
    output int          overflow_seen,
    output int          underflow_seen
);
    import spq_pkg::*;

    // One result of the queue, as it leaves on m_axis.
    typedef struct packed {
        status_t                 status;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
        logic [OCC_W-1:0]        occupancy;
    } pop_result_t;

    pop_result_t             queued_results[$];
    pop_result_t             got;
    pop_result_t             want;
    pop_result_t             fresh;
    logic signed [KEY_W-1:0] row_key   [DEPTH];
    logic signed [VAL_W-1:0] row_value [DEPTH];
    int                      fill;
    int                      mismatches;
    int                      n_ok;
    int                      n_over;
    int                      n_under;

    // Apply one operation to the shadow row and return the result it gives.
    task automatic apply_op(input logic kind, input logic signed [KEY_W-1:0] key,
                            input logic signed [VAL_W-1:0] value, output pop_result_t res);
        int pos;
        res.status = ST_OK;
        res.key    = '0;
        res.value  = '0;
        if (kind == KIND_ENQ)
        begin
            if (fill >= DEPTH)
            begin
                res.status = ST_OVERFLOW;
            end
            else
            begin
                // Entries with a strictly larger key move up, so equal keys keep the
                // newest pair on top.
                pos = fill;
                while (pos > 0 && row_key[pos-1] > key)
                begin
                    row_key[pos]   = row_key[pos-1];
                    row_value[pos] = row_value[pos-1];
                    pos--;
                end
                row_key[pos]   = key;
                row_value[pos] = value;
                fill++;
            end
        end
        else if (fill == 0)
        begin
            res.status = ST_UNDERFLOW;
        end
        else
        begin
            fill--;
            res.key   = row_key[fill];
            res.value = row_value[fill];
        end
        res.occupancy = OCC_W'(fill);
    endtask

    // Watch both channels; results are matched before the new input is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill       = 0;
            mismatches = 0;
            n_ok       = 0;
            n_over     = 0;
            n_under    = 0;
            queued_results.delete();
            fail_count     <= 0;
            pending        <= 0;
            ok_seen        <= 0;
            overflow_seen  <= 0;
            underflow_seen <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status    = status_t'(m_axis_tuser);
                got.key       = m_axis_tdata[31:0];
                got.value     = m_axis_tdata[63:32];
                got.occupancy = m_axis_tdata[67:64];
                case (got.status)
                    ST_OK:        n_ok++;
                    ST_OVERFLOW:  n_over++;
                    default:      n_under++;
                endcase
                if (queued_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing outstanding: status %0d key %h",
                                 $realtime, got.status, got.key);
                end
                else
                begin
                    want = queued_results.pop_front();
                    if (got.status != want.status || got.key != want.key ||
                        got.value != want.value || got.occupancy != want.occupancy)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch, expected status %0d key %h value %h occ %0d",
                                     $realtime, want.status, want.key, want.value,
                                     want.occupancy);
                            $display("%0t:          actual   status %0d key %h value %h occ %0d",
                                     $realtime, got.status, got.key, got.value,
                                     got.occupancy);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_op(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[63:32], fresh);
                queued_results.push_back(fresh);
            end
            fail_count     <= mismatches;
            pending        <= queued_results.size();
            ok_seen        <= n_ok;
            overflow_seen  <= n_over;
            underflow_seen <= n_under;
        end
    end

endmodule

### tb/testbench.sv
// Top of the sorted priority queue testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    import spq_pkg::*;

    localparam int DEPTH       = 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 60;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [31:0] item_key, [63:32] item_value
    logic [0:0]  s_axis_tuser;   // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;   // [31:0] removed_key, [63:32] removed_value,
                                 // [67:64] occupancy, [71:68] zero
    logic [1:0]  m_axis_tuser;   // [1:0] status

    int   fail_count;
    int   pending;
    int   ok_seen;
    int   overflow_seen;
    int   underflow_seen;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    int   hold_left = 0;
    int   cycle_count = 0;
    int   items_sent = 0;
    logic hold_request = 1'b0;

    sorted_priority_queue #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    spq_result_check #(
        .DEPTH(DEPTH)
    ) u_result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .ok_seen       (ok_seen),
        .overflow_seen (overflow_seen),
        .underflow_seen(underflow_seen)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Output side: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_request)
            hold_left = HOLD_CYCLES;
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one operation, with random idle cycles ahead of it, and wait for its transfer.
    task automatic push_op(input logic kind, input logic [31:0] key, input logic [31:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Stop offering and wait until every outstanding result has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Keys lean toward a few small values and the extremes so ties and order edges occur.
    function automatic logic [31:0] pick_key();
        logic [31:0] k;
        case ($urandom_range(2))
            0:       k = $urandom;
            1:       k = $urandom_range(8) - 4;
            default:
            begin
                case ($urandom_range(3))
                    0:       k = 32'h7FFF_FFFF;
                    1:       k = 32'h8000_0000;
                    2:       k = 32'h0000_0000;
                    default: k = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return k;
    endfunction

    // Random operations in bursts with a 25, 50 or 75 percent enqueue share, so the queue fills and empties.
    task automatic random_ops(input int count);
        int enq_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0:       enq_pct = 25;
                    1:       enq_pct = 50;
                    default: enq_pct = 75;
                endcase
            end
            push_op(($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ, pick_key(), $urandom);
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_ENQ;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty dequeue, extreme keys and values, ties, full queue, drain past empty.
        push_op(KIND_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_op(KIND_ENQ, 32'h7FFF_FFFF, 32'h0000_0000);
        push_op(KIND_ENQ, 32'h8000_0000, 32'hFFFF_FFFF);
        push_op(KIND_ENQ, 32'h0000_0000, 32'h7FFF_FFFF);
        push_op(KIND_ENQ, 32'hFFFF_FFFF, 32'h8000_0000);
        push_op(KIND_ENQ, 32'h0000_0005, 32'h0000_0001);
        push_op(KIND_ENQ, 32'h0000_0005, 32'h0000_0002);
        push_op(KIND_ENQ, 32'h7FFF_FFFF, 32'h1234_5678);
        push_op(KIND_ENQ, 32'h8000_0000, 32'hA5A5_A5A5);
        push_op(KIND_ENQ, 32'h0000_0001, 32'h5A5A_5A5A);
        for (int i = 0; i < DEPTH + 1; i++)
            push_op(KIND_DEQ, $urandom, $urandom);
        push_op(KIND_ENQ, 32'h0000_0000, 32'h0000_0000);
        push_op(KIND_DEQ, 32'h0000_0000, 32'h0000_0000);
        wait_drained();

        // Four pacing phases: none, sender idle, receiver stalls, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct  =  (phase == 1) ? 50 : (phase == 3) ? 29 : 0;
            stall_pct <= (phase == 2) ? 50 : (phase == 3) ? 29 : 0;
            if (phase == 0)
            begin
                // Long output hold-off while input keeps coming, so the block backs up.
                hold_request <= 1'b1;
                @(posedge clk);
                hold_request <= 1'b0;
                for (int i = 0; i < 20; i++)
                    push_op(($urandom_range(1) == 0) ? KIND_ENQ : KIND_DEQ, pick_key(), $urandom);
                wait_drained();
            end
            random_ops(400);
            wait_drained();
        end

        repeat (5) @(posedge clk);
        $display("Sent %0d operations over four pacing phases and one long output hold-off.",
                 items_sent);
        $display("Results seen: %0d ok, %0d overflow, %0d underflow; %0d mismatches.",
                 ok_seen, overflow_seen, underflow_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
